@@ design/rspp_pkg.sv @@
`default_nettype none
package rspp_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_ORIGIN = 2'd0;
	localparam logic [OP_W-1:0] OP_DIR = 2'd1;
	localparam logic [OP_W-1:0] OP_POINT = 2'd2;

	localparam int COORD_W = 32;
	localparam int RADIUS_W = 31;
	localparam int HIT_INDEX_W = 10;
	localparam int DIST_W = 31;
	localparam int BEST_W = 32;

	// datapath widths
	localparam int OC_W = COORD_W + 1;
	localparam int PROD_W = 2 * OC_W;
	localparam int B_W = 50;
	localparam int SQ_W = 51;
	localparam int C_W = 52;
	localparam int BB_W = 63;
	localparam int DISC_W = BB_W + 2;
	localparam int T_W = 52;
	localparam int FRAC_W = 16;
	localparam int BSQ_LIM = 39;

	localparam logic [BB_W-1:0] DISC_CAP = {1'b1, {(BB_W-1){1'b0}}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(65536);

	// square root unit
	localparam int ROOT_W = 40;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
	localparam int X_W = 2 * SQRT_STEPS;
	localparam int REM_W = ROOT_W + 4;

endpackage
`default_nettype wire

@@ design/rspp_mul.sv @@
`default_nettype none
module rspp_mul (
	input  wire logic                                 clk,
	input  wire logic signed [rspp_pkg::OC_W-1:0]     a,
	input  wire logic signed [rspp_pkg::OC_W-1:0]     b,
	output logic signed [rspp_pkg::PROD_W-1:0]        p
);

	logic signed [rspp_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule
`default_nettype wire

@@ design/rspp_isqrt.sv @@
`default_nettype none
module rspp_isqrt (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [rspp_pkg::BB_W-1:0]         radicand,
	output logic                                   done,
	output logic [rspp_pkg::ROOT_W-1:0]            root
);

	logic                                busy_q;
	logic                                done_q;
	logic [rspp_pkg::SQRT_CNT_W-1:0]     cnt_q;
	logic [rspp_pkg::X_W-1:0]            x_q;
	logic [rspp_pkg::REM_W-1:0]          rem_q;
	logic [rspp_pkg::ROOT_W-1:0]         root_q;
	logic [rspp_pkg::REM_W-1:0]          rem_sh;
	logic [rspp_pkg::REM_W-1:0]          trial;

	assign rem_sh = {rem_q[rspp_pkg::REM_W-3:0], x_q[rspp_pkg::X_W-1 -: 2]};
	assign trial = rspp_pkg::REM_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			x_q <= '0;
			rem_q <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				x_q <= {1'b0, radicand, {rspp_pkg::FRAC_W{1'b0}}};
				rem_q <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				x_q <= x_q << 2;
				if (rem_sh >= trial) begin
					rem_q <= rem_sh - trial;
					root_q <= {root_q[rspp_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[rspp_pkg::ROOT_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rspp_pkg::SQRT_CNT_W'(rspp_pkg::SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

@@ design/ray_sphere_nearest_point_pick_core.sv @@
// Nearest point pick along a ray, each point taken as a sphere of radius
// pick_radius (cfg_wen/cfg_wdata, reset 1.0 in Q15.16). The user must keep it
// written only while idle; the block does not enforce this. Input channel
// in_valid/in_stall carries op, coord_x/y/z and last_point. op origin and op
// direction are taken without raising in_stall; origin also restarts the
// point index and clears the best hit. A point request, once accepted, runs
// through 11 steps of the one shared 33x33 multiplier (dot product, squared
// length, radius squared, b squared in three partial products), the
// discriminant state, the wait on the bit-per-cycle square root and the
// update of the best hit; in_stall is high until it is back in idle. A missed
// sphere skips the root. A point with last_point set adds the report state
// and delivers one request on out_valid/out_stall with hit_found, hit_index
// and hit_distance from the output register; the set state then clears and
// the ray is kept. Other requests keep flowing while a result waits; only the
// next final point waits for the output register to be free. Points past the
// maximum count are not tested. Reset clears ray, count, best hit and output
// valid, and sets the radius.
`default_nettype none
module ray_sphere_nearest_point_pick_core (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       cfg_wen,
	input  wire logic [rspp_pkg::RADIUS_W-1:0]              cfg_wdata,
	input  wire logic                                       in_valid,
	output logic                                            in_stall,
	input  wire logic [rspp_pkg::OP_W-1:0]                  op,
	input  wire logic signed [rspp_pkg::COORD_W-1:0]        coord_x,
	input  wire logic signed [rspp_pkg::COORD_W-1:0]        coord_y,
	input  wire logic signed [rspp_pkg::COORD_W-1:0]        coord_z,
	input  wire logic                                       last_point,
	output logic                                            out_valid,
	input  wire logic                                       out_stall,
	output logic                                            hit_found,
	output logic [rspp_pkg::HIT_INDEX_W-1:0]                hit_index,
	output logic [rspp_pkg::DIST_W-1:0]                     hit_distance
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_DISC = 3'd2;
	localparam logic [2:0] S_ROOT = 3'd3;
	localparam logic [2:0] S_UPD = 3'd4;
	localparam logic [2:0] S_REPORT = 3'd5;

	// multiplier schedule
	localparam logic [3:0] MS_BX = 4'd0;
	localparam logic [3:0] MS_BY = 4'd1;
	localparam logic [3:0] MS_BZ = 4'd2;
	localparam logic [3:0] MS_SX = 4'd3;
	localparam logic [3:0] MS_SY = 4'd4;
	localparam logic [3:0] MS_SZ = 4'd5;
	localparam logic [3:0] MS_R2 = 4'd6;
	localparam logic [3:0] MS_HH = 4'd7;
	localparam logic [3:0] MS_HL = 4'd8;
	localparam logic [3:0] MS_LL = 4'd9;
	localparam logic [3:0] MS_END = 4'd10;

	logic [2:0]                                 state_q;
	logic [3:0]                                 step_q;
	logic [rspp_pkg::RADIUS_W-1:0]              radius_q;
	logic signed [rspp_pkg::COORD_W-1:0]        origin_q [3];
	logic signed [rspp_pkg::COORD_W-1:0]        dir_q [3];
	logic signed [rspp_pkg::OC_W-1:0]           oc_q [3];
	logic                                       last_q;
	logic signed [rspp_pkg::B_W-1:0]            b_q;
	logic [rspp_pkg::SQ_W-1:0]                  sq_q;
	logic signed [rspp_pkg::C_W-1:0]            c_q;
	logic [rspp_pkg::BB_W-1:0]                  bb_q;
	logic signed [rspp_pkg::T_W-1:0]            t_q;
	logic                                       tok_q;
	logic [rspp_pkg::CNT_W-1:0]                 cnt_q;
	logic [rspp_pkg::BEST_W-1:0]                best_dist_q;
	logic [rspp_pkg::HIT_INDEX_W-1:0]           best_idx_q;
	logic                                       any_hit_q;
	logic                                       out_valid_q;
	logic                                       hit_found_q;
	logic [rspp_pkg::HIT_INDEX_W-1:0]           hit_index_q;
	logic [rspp_pkg::DIST_W-1:0]                hit_distance_q;

	logic                                       in_acc;
	logic signed [rspp_pkg::OC_W-1:0]           mul_a;
	logic signed [rspp_pkg::OC_W-1:0]           mul_b;
	logic signed [rspp_pkg::PROD_W-1:0]         prod;
	logic [rspp_pkg::B_W-1:0]                   ub;
	logic                                       big;
	logic [rspp_pkg::BB_W-1:0]                  bbc;
	logic signed [rspp_pkg::DISC_W-1:0]         disc_w;
	logic [rspp_pkg::BB_W-1:0]                  disc_c;
	logic                                       sqrt_start;
	logic                                       sqrt_done;
	logic [rspp_pkg::ROOT_W-1:0]                root;
	logic signed [rspp_pkg::T_W-1:0]            negb;
	logic signed [rspp_pkg::T_W-1:0]            rootx;
	logic signed [rspp_pkg::T_W-1:0]            t_lo;
	logic signed [rspp_pkg::T_W-1:0]            t_hi;
	logic signed [rspp_pkg::T_W-1:0]            t_sel;
	logic [rspp_pkg::DIST_W-1:0]                tsat;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;

	// |b| split for b squared
	assign ub = rspp_pkg::B_W'(b_q[rspp_pkg::B_W-1] ? -b_q : b_q);
	assign big = |ub[rspp_pkg::B_W-1:rspp_pkg::BSQ_LIM];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			MS_BX: begin mul_a = oc_q[0]; mul_b = rspp_pkg::OC_W'(dir_q[0]); end
			MS_BY: begin mul_a = oc_q[1]; mul_b = rspp_pkg::OC_W'(dir_q[1]); end
			MS_BZ: begin mul_a = oc_q[2]; mul_b = rspp_pkg::OC_W'(dir_q[2]); end
			MS_SX: begin mul_a = oc_q[0]; mul_b = oc_q[0]; end
			MS_SY: begin mul_a = oc_q[1]; mul_b = oc_q[1]; end
			MS_SZ: begin mul_a = oc_q[2]; mul_b = oc_q[2]; end
			MS_R2: begin
				mul_a = rspp_pkg::OC_W'(radius_q);
				mul_b = rspp_pkg::OC_W'(radius_q);
			end
			MS_HH: begin
				mul_a = rspp_pkg::OC_W'(ub[rspp_pkg::BSQ_LIM-1:rspp_pkg::FRAC_W]);
				mul_b = rspp_pkg::OC_W'(ub[rspp_pkg::BSQ_LIM-1:rspp_pkg::FRAC_W]);
			end
			MS_HL: begin
				mul_a = rspp_pkg::OC_W'(ub[rspp_pkg::BSQ_LIM-1:rspp_pkg::FRAC_W]);
				mul_b = rspp_pkg::OC_W'(ub[rspp_pkg::FRAC_W-1:0]);
			end
			MS_LL: begin
				mul_a = rspp_pkg::OC_W'(ub[rspp_pkg::FRAC_W-1:0]);
				mul_b = rspp_pkg::OC_W'(ub[rspp_pkg::FRAC_W-1:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	rspp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// discriminant with caps
	always_comb begin
		if (big || bb_q > rspp_pkg::DISC_CAP) begin
			bbc = rspp_pkg::DISC_CAP;
		end else begin
			bbc = bb_q;
		end
		disc_w = $signed({2'b00, bbc})
			- $signed({{(rspp_pkg::DISC_W-rspp_pkg::C_W){c_q[rspp_pkg::C_W-1]}}, c_q});
		if (disc_w > $signed({2'b00, rspp_pkg::DISC_CAP})) begin
			disc_c = rspp_pkg::DISC_CAP;
		end else begin
			disc_c = disc_w[rspp_pkg::BB_W-1:0];
		end
	end

	assign sqrt_start = (state_q == S_DISC) && !disc_w[rspp_pkg::DISC_W-1];

	rspp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (disc_c),
		.done     (sqrt_done),
		.root     (root)
	);

	// near and far crossing
	assign negb = -$signed({{(rspp_pkg::T_W-rspp_pkg::B_W){b_q[rspp_pkg::B_W-1]}}, b_q});
	assign rootx = $signed({{(rspp_pkg::T_W-rspp_pkg::ROOT_W){1'b0}}, root});
	assign t_lo = negb - rootx;
	assign t_hi = negb + rootx;
	assign t_sel = t_lo[rspp_pkg::T_W-1] ? t_hi : t_lo;

	assign tsat = (t_q > $signed(rspp_pkg::T_W'(rspp_pkg::DIST_MAX)))
		? rspp_pkg::DIST_MAX : t_q[rspp_pkg::DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			radius_q <= rspp_pkg::RADIUS_RST;
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				dir_q[i] <= '0;
				oc_q[i] <= '0;
			end
			last_q <= 1'b0;
			b_q <= '0;
			sq_q <= '0;
			c_q <= '0;
			bb_q <= '0;
			t_q <= '0;
			tok_q <= 1'b0;
			cnt_q <= '0;
			best_dist_q <= '1;
			best_idx_q <= '0;
			any_hit_q <= 1'b0;
			out_valid_q <= 1'b0;
			hit_found_q <= 1'b0;
			hit_index_q <= '0;
			hit_distance_q <= '0;
		end else begin
			if (cfg_wen) begin
				radius_q <= cfg_wdata;
			end
			if (state_q == S_REPORT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (op)
							rspp_pkg::OP_ORIGIN: begin
								origin_q[0] <= coord_x;
								origin_q[1] <= coord_y;
								origin_q[2] <= coord_z;
								cnt_q <= '0;
								best_dist_q <= '1;
								best_idx_q <= '0;
								any_hit_q <= 1'b0;
							end
							rspp_pkg::OP_DIR: begin
								dir_q[0] <= coord_x;
								dir_q[1] <= coord_y;
								dir_q[2] <= coord_z;
							end
							rspp_pkg::OP_POINT: begin
								last_q <= last_point;
								if (cnt_q < rspp_pkg::CNT_W'(rspp_pkg::MAX_POINTS)) begin
									oc_q[0] <= rspp_pkg::OC_W'(origin_q[0])
										- rspp_pkg::OC_W'(coord_x);
									oc_q[1] <= rspp_pkg::OC_W'(origin_q[1])
										- rspp_pkg::OC_W'(coord_y);
									oc_q[2] <= rspp_pkg::OC_W'(origin_q[2])
										- rspp_pkg::OC_W'(coord_z);
									b_q <= '0;
									sq_q <= '0;
									step_q <= MS_BX;
									state_q <= S_MUL;
								end else if (last_point) begin
									state_q <= S_REPORT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						MS_BY, MS_BZ, MS_SX: begin
							b_q <= b_q + rspp_pkg::B_W'(prod >>> rspp_pkg::FRAC_W);
						end
						MS_SY, MS_SZ, MS_R2: begin
							sq_q <= sq_q + rspp_pkg::SQ_W'(prod >>> rspp_pkg::FRAC_W);
						end
						MS_HH: begin
							c_q <= rspp_pkg::C_W'(sq_q)
								- rspp_pkg::C_W'(prod >>> rspp_pkg::FRAC_W);
						end
						MS_HL: begin
							bb_q <= rspp_pkg::BB_W'(prod) << rspp_pkg::FRAC_W;
						end
						MS_LL: begin
							bb_q <= bb_q + (rspp_pkg::BB_W'(prod) << 1);
						end
						MS_END: begin
							bb_q <= bb_q + rspp_pkg::BB_W'(prod >>> rspp_pkg::FRAC_W);
							state_q <= S_DISC;
						end
						default: begin
						end
					endcase
				end
				S_DISC: begin
					if (disc_w[rspp_pkg::DISC_W-1]) begin
						tok_q <= 1'b0;
						state_q <= S_UPD;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sqrt_done) begin
						t_q <= t_sel;
						tok_q <= !t_sel[rspp_pkg::T_W-1];
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (tok_q && {1'b0, tsat} < best_dist_q) begin
						best_dist_q <= {1'b0, tsat};
						best_idx_q <= rspp_pkg::HIT_INDEX_W'(cnt_q);
						any_hit_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					state_q <= last_q ? S_REPORT : S_IDLE;
				end
				S_REPORT: begin
					if (!out_valid_q || !out_stall) begin
						hit_found_q <= any_hit_q;
						hit_index_q <= any_hit_q ? best_idx_q : '0;
						hit_distance_q <= any_hit_q ? best_dist_q[rspp_pkg::DIST_W-1:0] : '0;
						cnt_q <= '0;
						best_dist_q <= '1;
						best_idx_q <= '0;
						any_hit_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign hit_found = hit_found_q;
	assign hit_index = hit_index_q;
	assign hit_distance = hit_distance_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rspp_pkg::CNT_W'(rspp_pkg::MAX_POINTS))
		else $error("point count past maximum");

	a_best_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!any_hit_q |-> best_dist_q == '1)
		else $error("best distance set without a hit");

	a_nohit_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_found |-> hit_index == '0 && hit_distance == '0)
		else $error("miss result carries index or distance");

	a_origin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op == rspp_pkg::OP_ORIGIN |=> cnt_q == '0 && !any_hit_q)
		else $error("origin load did not restart the set");

	a_root_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == S_ROOT)
		else $error("root finished outside root wait");

endmodule
`default_nettype wire
